@@ src/cfri_pkg.sv @@
// ----------------------------------------------------------------------------
// cfri_pkg: shared constants for the CF card register interface
// Register addresses, status and command codes, disk access codes and the
// address table of the mode unlock sequence.
// ----------------------------------------------------------------------------
package cfri_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 37;
    localparam int unsigned LBA_W      = 28;
    localparam int unsigned SECCNT_W   = 9;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned OP_W       = 2;

    localparam int unsigned SECTOR_BYTES_DEF = 512;

    // Register map
    localparam logic [ADDR_W-1:0] A_STS  = 32'h080C_0000;
    localparam logic [ADDR_W-1:0] A_CMD  = 32'h088E_0000;
    localparam logic [ADDR_W-1:0] A_ERR  = 32'h0882_0000;
    localparam logic [ADDR_W-1:0] A_SEC  = 32'h0884_0000;
    localparam logic [ADDR_W-1:0] A_LBA0 = 32'h0886_0000;
    localparam logic [ADDR_W-1:0] A_LBA1 = 32'h0888_0000;
    localparam logic [ADDR_W-1:0] A_LBA2 = 32'h088A_0000;
    localparam logic [ADDR_W-1:0] A_LBA3 = 32'h088C_0000;
    localparam logic [ADDR_W-1:0] A_DATA = 32'h0880_0000;

    // Unlock sequence addresses beyond the table
    localparam logic [ADDR_W-1:0] A_MODE_MEDIA = 32'h0800_0000 + (32'h0040_0003 << 1);
    localparam logic [ADDR_W-1:0] A_MODE_ROM   = 32'h0800_0000 + (32'h0040_0004 << 1);
    localparam logic [ADDR_W-1:0] A_MEDIA_GO   = 32'h0900_0000;
    localparam logic [ADDR_W-1:0] A_ROM_STEP1  = 32'h0800_01E4;
    localparam logic [ADDR_W-1:0] A_ROM_STEP2  = 32'h0800_0188;

    // Unlock steps with special handling
    localparam logic [STEP_W-1:0] STEP_TABLE_LAST = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MODE_SEL   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_AFTER_SEL  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CHOOSE     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_ROM_A      = 4'd11;
    localparam logic [STEP_W-1:0] STEP_ROM_B      = 4'd12;
    localparam logic [STEP_W-1:0] STEP_ROM_C      = 4'd13;
    localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;

    // Status codes
    localparam logic [HALF_W-1:0] STS_INSERTED = 16'h0050;
    localparam logic [HALF_W-1:0] STS_REMOVED  = 16'h0000;
    localparam logic [HALF_W-1:0] STS_READY    = 16'h0058;
    localparam logic [HALF_W-1:0] STS_DRQ      = 16'h0008;
    localparam logic [HALF_W-1:0] STS_BUSY     = 16'h0080;

    // Command codes
    localparam logic [HALF_W-1:0] CMD_LBA   = 16'h00E0;
    localparam logic [HALF_W-1:0] CMD_READ  = 16'h0020;
    localparam logic [HALF_W-1:0] CMD_WRITE = 16'h0030;

    // Bus access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Disk store request codes
    localparam logic [OP_W-1:0] DISK_NONE  = 2'd0;
    localparam logic [OP_W-1:0] DISK_READ  = 2'd1;
    localparam logic [OP_W-1:0] DISK_WRITE = 2'd2;

    localparam logic [LBA_W-1:0] LBA_TOP_MASK = 28'hF;

    // Expected address at each table-driven unlock step
    function automatic logic [ADDR_W-1:0] unlock_addr(input logic [STEP_W-1:0] step);
        logic [ADDR_W-1:0] a;
        a = '0;
        case (step)
            4'd0:    a = 32'h08E0_0002;
            4'd1:    a = 32'h0800_000E;
            4'd2:    a = 32'h0880_1FFC;
            4'd3:    a = 32'h0800_104A;
            4'd4:    a = 32'h0880_0612;
            4'd5:    a = 32'h0800_0000;
            4'd6:    a = 32'h0880_1B66;
            4'd8:    a = 32'h0800_080E;
            4'd9:    a = 32'h0800_0000;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/cf_card_register_interface.sv @@
// ----------------------------------------------------------------------------
// cf_card_register_interface: CF card register file on a cartridge bus
// Decodes one bus access per request, keeps the task-file registers and the
// data position, issues disk store requests and tracks the mode unlock.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tuser func, s_tdata addr,wdata
//  m_*     | out | m_tvalid/m_tready  | m_tdata result of one access
//
//  One request per cycle while the result side is ready; each request
//  goes through the input register, then the result register, and the
//  decode and state update sit between the two. The input side keeps
//  accepting while a result waits, until both registers are full. rst_n
//  clears the valid flags, device state and unlock sequence to ROM mode.
// ----------------------------------------------------------------------------
module cf_card_register_interface #(
    parameter int unsigned SECTOR_BYTES = cfri_pkg::SECTOR_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [31:0] addr, [47:32] wdata
    input  logic         s_tuser,   // [0] func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // [15:0] rdata, [16] unmapped, [17] bad_value,
                                    // [19:18] disk_op, [56:20] disk_addr,
                                    // [72:57] disk_wdata, [73] flush,
                                    // [101:74] flush_lba, [110:102] flush_sectors,
                                    // [111] cart_mode
);
    import cfri_pkg::*;

    localparam int unsigned SB_W   = $clog2(SECTOR_BYTES + 1);
    localparam int unsigned PROD_W = LBA_W + SB_W;

    // Input register
    logic                in_valid_reg;
    logic                in_func_reg;
    logic [ADDR_W-1:0]   in_addr_reg;
    logic [HALF_W-1:0]   in_wdata_reg;

    // Result register
    logic                out_valid_reg;
    logic [HALF_W-1:0]   rdata_reg,      rdata_next;
    logic                unmapped_reg,   unmapped_next;
    logic                bad_reg,        bad_next;
    logic [OP_W-1:0]     op_reg,         op_next;
    logic [POS_W-1:0]    daddr_reg,      daddr_next;
    logic [HALF_W-1:0]   dwdata_reg,     dwdata_next;
    logic                flush_reg,      flush_next;
    logic [LBA_W-1:0]    flba_reg,       flba_next;
    logic [SECCNT_W-1:0] fsec_reg,       fsec_next;

    // Device state
    logic [BYTE_W-1:0]   status_reg,     status_next;
    logic [HALF_W-1:0]   command_reg,    command_next;
    logic [BYTE_W-1:0]   seccnt_reg,     seccnt_next;
    logic [BYTE_W-1:0]   lba0_reg,       lba0_next;
    logic [BYTE_W-1:0]   lba1_reg,       lba1_next;
    logic [BYTE_W-1:0]   lba2_reg,       lba2_next;
    logic [BYTE_W-1:0]   lba3_reg,       lba3_next;
    logic [POS_W-1:0]    pos_reg,        pos_next;
    logic [STEP_W-1:0]   step_reg,       step_next;
    logic                mode_reg,       mode_next;

    logic                advance;
    logic [LBA_W-1:0]    lba_val;
    logic [SECCNT_W-1:0] sec_count;
    logic [PROD_W-1:0]   start_prod;
    logic [POS_W-1:0]    run_start;
    logic [POS_W-1:0]    run_end;
    logic [POS_W-1:0]    pos_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign lba_val    = {lba3_reg[3:0], lba2_reg, lba1_reg, lba0_reg};
    assign sec_count  = (seccnt_reg == '0) ? SECCNT_W'(256) : SECCNT_W'(seccnt_reg);
    assign start_prod = PROD_W'(lba_val) * PROD_W'(SECTOR_BYTES);
    assign run_start  = (PROD_W >= POS_W) ? start_prod[POS_W-1:0] : POS_W'(start_prod);
    assign run_end    = run_start + POS_W'(sec_count) * POS_W'(SECTOR_BYTES);
    assign pos_inc    = pos_reg + POS_W'(2);

    always_comb
    begin
        rdata_next    = '0;
        unmapped_next = 1'b0;
        bad_next      = 1'b0;
        op_next       = DISK_NONE;
        daddr_next    = '0;
        dwdata_next   = '0;
        flush_next    = 1'b0;
        flba_next     = '0;
        fsec_next     = '0;
        status_next   = status_reg;
        command_next  = command_reg;
        seccnt_next   = seccnt_reg;
        lba0_next     = lba0_reg;
        lba1_next     = lba1_reg;
        lba2_next     = lba2_reg;
        lba3_next     = lba3_reg;
        pos_next      = pos_reg;
        step_next     = step_reg;
        mode_next     = mode_reg;

        if (in_func_reg == FUNC_READ)
        begin
            case (in_addr_reg)
                A_STS:  rdata_next = HALF_W'(status_reg);
                A_CMD:  rdata_next = command_reg;
                A_ERR:  unmapped_next = 1'b1;
                A_SEC:  rdata_next = HALF_W'(seccnt_reg);
                A_LBA0: rdata_next = HALF_W'(lba0_reg);
                A_LBA1: rdata_next = HALF_W'(lba1_reg);
                A_LBA2: rdata_next = HALF_W'(lba2_reg);
                A_LBA3: rdata_next = HALF_W'(lba3_reg);
                A_DATA:
                begin
                    op_next    = DISK_READ;
                    daddr_next = pos_reg;
                    pos_next   = pos_inc;
                end
                default:
                begin
                    unmapped_next = 1'b1;
                    // advance or drop the unlock sequence
                    if (step_reg <= STEP_TABLE_LAST && step_reg != STEP_MODE_SEL
                        && in_addr_reg == unlock_addr(step_reg))
                        step_next = step_reg + STEP_W'(1);
                    else if (step_reg == STEP_MODE_SEL
                             && (in_addr_reg == A_MODE_MEDIA || in_addr_reg == A_MODE_ROM))
                        step_next = STEP_AFTER_SEL;
                    else if (step_reg == STEP_CHOOSE && in_addr_reg == A_MEDIA_GO)
                    begin
                        step_next = STEP_IDLE;
                        mode_next = 1'b1;
                    end
                    else if ((step_reg == STEP_CHOOSE || step_reg == STEP_ROM_A)
                             && in_addr_reg == A_ROM_STEP1)
                        step_next = step_reg + STEP_W'(1);
                    else if (step_reg == STEP_ROM_B && in_addr_reg == A_ROM_STEP2)
                        step_next = STEP_ROM_C;
                    else if (step_reg == STEP_ROM_C && in_addr_reg == A_ROM_STEP2)
                    begin
                        step_next = STEP_IDLE;
                        mode_next = 1'b0;
                    end
                    else
                        step_next = STEP_IDLE;
                end
            endcase
        end
        else
        begin
            case (in_addr_reg)
                A_STS:
                begin
                    if (in_wdata_reg == STS_INSERTED)
                        status_next = STS_INSERTED[BYTE_W-1:0];
                    else if (in_wdata_reg == STS_READY || in_wdata_reg == STS_BUSY)
                        status_next = STS_READY[BYTE_W-1:0];
                    else if (in_wdata_reg != STS_REMOVED && in_wdata_reg != STS_DRQ)
                        bad_next = 1'b1;
                end
                A_CMD:
                begin
                    command_next = in_wdata_reg;
                    if (in_wdata_reg == CMD_LBA)
                        status_next = STS_READY[BYTE_W-1:0];
                    else if (in_wdata_reg == CMD_READ || in_wdata_reg == CMD_WRITE)
                    begin
                        status_next = STS_READY[BYTE_W-1:0];
                        pos_next    = run_start;
                    end
                    else
                        bad_next = 1'b1;
                end
                A_SEC:  seccnt_next = in_wdata_reg[BYTE_W-1:0];
                A_LBA0: lba0_next   = in_wdata_reg[BYTE_W-1:0];
                A_LBA1: lba1_next   = in_wdata_reg[BYTE_W-1:0];
                A_LBA2: lba2_next   = in_wdata_reg[BYTE_W-1:0];
                A_LBA3: lba3_next   = in_wdata_reg[BYTE_W-1:0];
                A_DATA:
                begin
                    op_next     = DISK_WRITE;
                    daddr_next  = pos_reg;
                    dwdata_next = in_wdata_reg;
                    pos_next    = pos_inc;
                    // flush when this halfword closes the sector run
                    if (pos_inc == run_end)
                    begin
                        flush_next = 1'b1;
                        flba_next  = lba_val;
                        fsec_next  = sec_count;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            command_reg   <= '0;
            seccnt_reg    <= '0;
            lba0_reg      <= '0;
            lba1_reg      <= '0;
            lba2_reg      <= '0;
            lba3_reg      <= '0;
            pos_reg       <= '0;
            step_reg      <= STEP_IDLE;
            mode_reg      <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                status_reg  <= status_next;
                command_reg <= command_next;
                seccnt_reg  <= seccnt_next;
                lba0_reg    <= lba0_next;
                lba1_reg    <= lba1_next;
                lba2_reg    <= lba2_next;
                lba3_reg    <= lba3_next;
                pos_reg     <= pos_next;
                step_reg    <= step_next;
                mode_reg    <= mode_next;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= s_tuser;
            in_addr_reg  <= s_tdata[31:0];
            in_wdata_reg <= s_tdata[47:32];
        end
        if (advance)
        begin
            rdata_reg    <= rdata_next;
            unmapped_reg <= unmapped_next;
            bad_reg      <= bad_next;
            op_reg       <= op_next;
            daddr_reg    <= daddr_next;
            dwdata_reg   <= dwdata_next;
            flush_reg    <= flush_next;
            flba_reg     <= flba_next;
            fsec_reg     <= fsec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {mode_reg, fsec_reg, flba_reg, flush_reg, dwdata_reg, daddr_reg,
                       op_reg, bad_reg, unmapped_reg, rdata_reg};

endmodule

@@ sim/cf_card_register_checker.sv @@
// ----------------------------------------------------------------------------
// cf_card_register_checker: result predictor and comparator
// Watches both stream channels of the CF card register interface. Every
// accepted bus access runs through a local model of the task-file registers,
// data position and unlock sequence; every accepted result is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cf_card_register_checker #(
    parameter int unsigned SECTOR_BYTES = cfri_pkg::SECTOR_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,   // [31:0] addr, [47:32] wdata
    input  logic         s_tuser,   // [0] func
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,   // rdata, unmapped, bad_value, disk_op, disk_addr,
                                    // disk_wdata, flush, flush_lba, flush_sectors,
                                    // cart_mode
    output int           fail_count,
    output int           pending
);

    import cfri_pkg::*;

    typedef struct packed {
        logic                cart_mode;
        logic [SECCNT_W-1:0] flush_sectors;
        logic [LBA_W-1:0]    flush_lba;
        logic                flush;
        logic [HALF_W-1:0]   disk_wdata;
        logic [POS_W-1:0]    disk_addr;
        logic [OP_W-1:0]     disk_op;
        logic                bad_value;
        logic                unmapped;
        logic [HALF_W-1:0]   rdata;
    } access_result_t;

    // Read addresses of the unlock walk, step 9 down to step 0
    localparam logic [9:0][ADDR_W-1:0] UNLOCK_SEQ = {
        32'h0800_0000, 32'h0800_080E, 32'h0000_0000, 32'h0880_1B66, 32'h0800_0000,
        32'h0880_0612, 32'h0800_104A, 32'h0880_1FFC, 32'h0800_000E, 32'h08E0_0002
    };

    logic [BYTE_W-1:0]      status_q;
    logic [HALF_W-1:0]      command_q;
    logic [BYTE_W-1:0]      seccnt_q;
    logic [3:0][BYTE_W-1:0] lba_q;
    logic [POS_W-1:0]       pos_q;
    logic [STEP_W-1:0]      step_q;
    logic                   mode_q;

    access_result_t access_results_due[$];
    access_result_t want;
    access_result_t got;

    function automatic access_result_t predict_access(input logic func,
                                                      input logic [ADDR_W-1:0] a,
                                                      input logic [HALF_W-1:0] v);
        access_result_t      r;
        logic [LBA_W-1:0]    lba_val;
        logic [SECCNT_W-1:0] sectors;
        logic [POS_W-1:0]    run_start;
        logic [POS_W-1:0]    run_end;
        r         = '0;
        lba_val   = {lba_q[3][3:0], lba_q[2], lba_q[1], lba_q[0]};
        sectors   = (seccnt_q == '0) ? 9'd256 : {1'b0, seccnt_q};
        run_start = POS_W'(64'(lba_val) * 64'(SECTOR_BYTES));
        run_end   = POS_W'(64'(run_start) + 64'(sectors) * 64'(SECTOR_BYTES));
        if (func == FUNC_READ) begin
            case (a)
                A_STS:  r.rdata = {8'h00, status_q};
                A_CMD:  r.rdata = command_q;
                A_ERR:  r.unmapped = 1'b1;
                A_SEC:  r.rdata = {8'h00, seccnt_q};
                A_LBA0: r.rdata = {8'h00, lba_q[0]};
                A_LBA1: r.rdata = {8'h00, lba_q[1]};
                A_LBA2: r.rdata = {8'h00, lba_q[2]};
                A_LBA3: r.rdata = {8'h00, lba_q[3]};
                A_DATA:
                begin
                    r.disk_op   = DISK_READ;
                    r.disk_addr = pos_q;
                    pos_q       = pos_q + 37'd2;
                end
                default:
                begin
                    r.unmapped = 1'b1;
                    // advance the unlock walk, drop back to idle on any stray read
                    if (step_q <= STEP_TABLE_LAST && step_q != STEP_MODE_SEL
                        && a == UNLOCK_SEQ[step_q])
                        step_q = step_q + 4'd1;
                    else if (step_q == STEP_MODE_SEL && (a == A_MODE_MEDIA || a == A_MODE_ROM))
                        step_q = STEP_AFTER_SEL;
                    else if (step_q == STEP_CHOOSE && a == A_MEDIA_GO)
                    begin
                        step_q = STEP_IDLE;
                        mode_q = 1'b1;
                    end
                    else if ((step_q == STEP_CHOOSE || step_q == STEP_ROM_A) && a == A_ROM_STEP1)
                        step_q = step_q + 4'd1;
                    else if (step_q == STEP_ROM_B && a == A_ROM_STEP2)
                        step_q = STEP_ROM_C;
                    else if (step_q == STEP_ROM_C && a == A_ROM_STEP2)
                    begin
                        step_q = STEP_IDLE;
                        mode_q = 1'b0;
                    end
                    else
                        step_q = STEP_IDLE;
                end
            endcase
        end
        else begin
            case (a)
                A_STS:
                begin
                    if (v == STS_INSERTED)
                        status_q = BYTE_W'(STS_INSERTED);
                    else if (v == STS_READY || v == STS_BUSY)
                        status_q = BYTE_W'(STS_READY);
                    else if (v != STS_REMOVED && v != STS_DRQ)
                        r.bad_value = 1'b1;
                end
                A_CMD:
                begin
                    command_q = v;
                    if (v == CMD_LBA)
                        status_q = BYTE_W'(STS_READY);
                    else if (v == CMD_READ || v == CMD_WRITE)
                    begin
                        status_q = BYTE_W'(STS_READY);
                        pos_q    = run_start;
                    end
                    else
                        r.bad_value = 1'b1;
                end
                A_SEC:  seccnt_q = v[7:0];
                A_LBA0: lba_q[0] = v[7:0];
                A_LBA1: lba_q[1] = v[7:0];
                A_LBA2: lba_q[2] = v[7:0];
                A_LBA3: lba_q[3] = v[7:0];
                A_DATA:
                begin
                    r.disk_op    = DISK_WRITE;
                    r.disk_addr  = pos_q;
                    r.disk_wdata = v;
                    pos_q        = pos_q + 37'd2;
                    if (pos_q == run_end)
                    begin
                        r.flush         = 1'b1;
                        r.flush_lba     = lba_val;
                        r.flush_sectors = sectors;
                    end
                end
                default: ;
            endcase
        end
        r.cart_mode = mode_q;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_q   = '0;
            command_q  = '0;
            seccnt_q   = '0;
            lba_q      = '0;
            pos_q      = '0;
            step_q     = STEP_IDLE;
            mode_q     = 1'b0;
            fail_count = 0;
            access_results_due.delete();
            pending <= 0;
        end
        else begin
            // compare before pushing: a request taken at this edge cannot answer at it
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (access_results_due.size() == 0)
                    note_mismatch("unexpected result", 64'd0, m_tdata[63:0]);
                else begin
                    want = access_results_due.pop_front();
                    if (got.rdata !== want.rdata)
                        note_mismatch("rdata", 64'(want.rdata), 64'(got.rdata));
                    if (got.unmapped !== want.unmapped)
                        note_mismatch("unmapped", 64'(want.unmapped), 64'(got.unmapped));
                    if (got.bad_value !== want.bad_value)
                        note_mismatch("bad_value", 64'(want.bad_value), 64'(got.bad_value));
                    if (got.disk_op !== want.disk_op)
                        note_mismatch("disk_op", 64'(want.disk_op), 64'(got.disk_op));
                    if (got.disk_addr !== want.disk_addr)
                        note_mismatch("disk_addr", 64'(want.disk_addr), 64'(got.disk_addr));
                    if (got.disk_wdata !== want.disk_wdata)
                        note_mismatch("disk_wdata", 64'(want.disk_wdata), 64'(got.disk_wdata));
                    if (got.flush !== want.flush)
                        note_mismatch("flush", 64'(want.flush), 64'(got.flush));
                    if (got.flush_lba !== want.flush_lba)
                        note_mismatch("flush_lba", 64'(want.flush_lba), 64'(got.flush_lba));
                    if (got.flush_sectors !== want.flush_sectors)
                        note_mismatch("flush_sectors", 64'(want.flush_sectors),
                                      64'(got.flush_sectors));
                    if (got.cart_mode !== want.cart_mode)
                        note_mismatch("cart_mode", 64'(want.cart_mode), 64'(got.cart_mode));
                end
            end
            if (s_tvalid && s_tready)
                access_results_due.push_back(predict_access(s_tuser, s_tdata[31:0],
                                                            s_tdata[47:32]));
            pending <= access_results_due.size();
        end
    end

endmodule

@@ sim/tb_cf_card_register_interface.sv @@
// ----------------------------------------------------------------------------
// tb_cf_card_register_interface: stimulus and verdict for the CF register block
// Drives a directed pass over register codes and limits, then random sector
// transfers, unlock walks toward media and ROM mode, register pokes and bus
// noise, with random idling on both channels. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_cf_card_register_interface;

    import cfri_pkg::*;

    localparam int unsigned ITEM_TARGET = 1700;
    localparam int unsigned CALM_AFTER  = 1450;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;

    int fail_count;
    int pending;
    int sent;
    int cycles;
    int gap_pct;
    bit calm;

    cf_card_register_interface dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cf_card_register_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cf_card_register_interface verification failed");
            $finish;
        end
    end

    // result side: ready bursts with random stalls, none once calm
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!calm && $urandom_range(2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic issue(input logic func, input logic [ADDR_W-1:0] addr,
                         input logic [HALF_W-1:0] wdata);
        // stop idling for the tail of the run, even inside a long transfer
        if (sent >= CALM_AFTER)
            calm = 1'b1;
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {wdata, addr};
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // hold off until every outstanding request has answered
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_reg_addr();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(8))
            0:       a = A_STS;
            1:       a = A_CMD;
            2:       a = A_ERR;
            3:       a = A_SEC;
            4:       a = A_LBA0;
            5:       a = A_LBA1;
            6:       a = A_LBA2;
            7:       a = A_LBA3;
            default: a = A_DATA;
        endcase
        return a;
    endfunction

    task automatic poke_register();
        logic [ADDR_W-1:0] a;
        logic [HALF_W-1:0] v;
        a = pick_reg_addr();
        v = HALF_W'($urandom);
        if (a == A_STS && $urandom_range(1) == 1)
        begin
            case ($urandom_range(4))
                0:       v = STS_INSERTED;
                1:       v = STS_READY;
                2:       v = STS_BUSY;
                3:       v = STS_REMOVED;
                default: v = STS_DRQ;
            endcase
        end
        else if (a == A_CMD && $urandom_range(1) == 1)
        begin
            case ($urandom_range(2))
                0:       v = CMD_LBA;
                1:       v = CMD_READ;
                default: v = CMD_WRITE;
            endcase
        end
        issue(1'($urandom_range(1)), a, v);
    endtask

    // one-sector write run; wrap puts the run at the top of the position space
    task automatic sector_write_run(input bit wrap);
        logic [LBA_W-1:0] lba;
        lba = wrap ? {LBA_W{1'b1}} : LBA_W'($urandom);
        issue(FUNC_WRITE, A_SEC, {8'($urandom), 8'd1});
        issue(FUNC_WRITE, A_LBA0, {8'($urandom), lba[7:0]});
        issue(FUNC_WRITE, A_LBA1, {8'($urandom), lba[15:8]});
        issue(FUNC_WRITE, A_LBA2, {8'($urandom), lba[23:16]});
        issue(FUNC_WRITE, A_LBA3, {8'($urandom), 4'($urandom), lba[27:24]});
        issue(FUNC_WRITE, A_CMD, ($urandom_range(4) == 0) ? CMD_READ : CMD_WRITE);
        for (int i = 0; i < 256; i++)
        begin
            if ($urandom_range(15) == 0)
                issue(FUNC_READ, A_STS, HALF_W'($urandom));
            if ($urandom_range(63) == 0)
                poke_register();
            issue(FUNC_WRITE, A_DATA, HALF_W'($urandom));
        end
    endtask

    task automatic sector_read_run();
        issue(FUNC_WRITE, A_SEC, HALF_W'($urandom));
        issue(FUNC_WRITE, A_LBA0, HALF_W'($urandom));
        issue(FUNC_WRITE, A_LBA1, HALF_W'($urandom));
        issue(FUNC_WRITE, A_LBA2, HALF_W'($urandom));
        issue(FUNC_WRITE, A_LBA3, HALF_W'($urandom));
        issue(FUNC_WRITE, A_CMD, ($urandom_range(3) == 0) ? CMD_WRITE : CMD_READ);
        repeat ($urandom_range(2, 12))
            issue(1'($urandom_range(3) == 0), A_DATA, HALF_W'($urandom));
    endtask

    task automatic unlock_walk(input bit to_media, input bit broken);
        logic [ADDR_W-1:0] a;
        for (int step = 0; step < 10; step++)
        begin
            if (step == int'(STEP_MODE_SEL))
                a = ($urandom_range(1) == 1) ? A_MODE_MEDIA : A_MODE_ROM;
            else
                a = unlock_addr(4'(step));
            // register traffic and writes anywhere must not disturb the walk
            if ($urandom_range(7) == 0)
                poke_register();
            if ($urandom_range(15) == 0)
                issue(FUNC_WRITE, ($urandom_range(1) == 1) ? a : 32'($urandom),
                      HALF_W'($urandom));
            if (broken && $urandom_range(6) == 0)
                issue(FUNC_READ, ($urandom_range(1) == 1) ? 32'($urandom) : A_ROM_STEP2,
                      HALF_W'($urandom));
            issue(FUNC_READ, a, HALF_W'($urandom));
        end
        if (to_media)
            issue(FUNC_READ, A_MEDIA_GO, HALF_W'($urandom));
        else begin
            issue(FUNC_READ, A_ROM_STEP1, HALF_W'($urandom));
            issue(FUNC_READ, A_ROM_STEP1, HALF_W'($urandom));
            if (broken && $urandom_range(1) == 0)
                issue(FUNC_READ, A_MEDIA_GO, HALF_W'($urandom));
            issue(FUNC_READ, A_ROM_STEP2, HALF_W'($urandom));
            issue(FUNC_READ, A_ROM_STEP2, HALF_W'($urandom));
        end
    endtask

    initial
    begin
        int unsigned pick;
        bit          first_run;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_READ;
        sent      = 0;
        cycles    = 0;
        calm      = 1'b0;
        gap_pct   = 10;
        first_run = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset values
        issue(FUNC_READ, A_STS, 16'hFFFF);
        issue(FUNC_READ, A_CMD, 16'h0000);
        issue(FUNC_READ, A_ERR, 16'h0000);
        issue(FUNC_READ, A_SEC, 16'h0000);
        issue(FUNC_READ, A_LBA0, 16'h0000);
        // status codes, accepted and rejected
        issue(FUNC_WRITE, A_STS, STS_INSERTED);
        issue(FUNC_WRITE, A_STS, STS_BUSY);
        issue(FUNC_WRITE, A_STS, STS_REMOVED);
        issue(FUNC_WRITE, A_STS, STS_DRQ);
        issue(FUNC_WRITE, A_STS, 16'hFFFF);
        issue(FUNC_WRITE, A_STS, STS_READY);
        issue(FUNC_READ, A_STS, 16'h0000);
        issue(FUNC_WRITE, A_CMD, CMD_LBA);
        issue(FUNC_WRITE, A_CMD, 16'hFFFF);
        issue(FUNC_READ, A_CMD, 16'h0000);
        // count of zero, all-ones LBA, position at the top of its range
        issue(FUNC_WRITE, A_SEC, 16'hFF00);
        issue(FUNC_READ, A_SEC, 16'h0000);
        issue(FUNC_WRITE, A_LBA0, 16'hFFFF);
        issue(FUNC_WRITE, A_LBA1, 16'hFFFF);
        issue(FUNC_WRITE, A_LBA2, 16'hFFFF);
        issue(FUNC_WRITE, A_LBA3, 16'hFFFF);
        issue(FUNC_READ, A_LBA3, 16'h0000);
        issue(FUNC_WRITE, A_CMD, CMD_WRITE);
        issue(FUNC_READ, A_DATA, 16'h0000);
        issue(FUNC_WRITE, A_DATA, 16'hFFFF);
        issue(FUNC_WRITE, A_ERR, 16'hFFFF);
        issue(FUNC_WRITE, 32'hFFFF_FFFF, 16'hFFFF);
        issue(FUNC_READ, 32'hFFFF_FFFF, 16'h0000);
        drain();

        while (sent < ITEM_TARGET)
        begin
            if (sent >= CALM_AFTER)
                calm = 1'b1;
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 6;
                    default: gap_pct = 30;
                endcase
            end
            pick = $urandom_range(99);
            if (first_run)
            begin
                sector_write_run(1'b1);
                first_run = 1'b0;
            end
            else if (pick < 3)
                sector_write_run($urandom_range(2) == 0);
            else if (pick < 13)
                sector_read_run();
            else if (pick < 25)
                unlock_walk(1'b1, $urandom_range(3) == 0);
            else if (pick < 35)
                unlock_walk(1'b0, $urandom_range(3) == 0);
            else if (pick < 80)
                poke_register();
            else if (pick < 90)
                issue(1'($urandom_range(1)), 32'($urandom), HALF_W'($urandom));
            else
                issue(1'($urandom_range(1)), {8'h08, 24'($urandom)}, HALF_W'($urandom));
            if (!calm && $urandom_range(49) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("cf_card_register_interface verification clean");
        else
            $display("cf_card_register_interface verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/cfri_pkg.sv
src/cf_card_register_interface.sv
sim/cf_card_register_checker.sv
sim/tb_cf_card_register_interface.sv
